[sv/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared widths, reset values, register indexes and interface types of the
// mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

   // payload field widths
   localparam int HEADING_W  = 9;
   localparam int SPEED_W    = 8;
   localparam int TURN_W     = 9;
   localparam int DUTY_W     = 8;

   // register file
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   typedef enum logic {
      CSR_CENTER_DUTY = 1'b0,
      CSR_SPEED_LIMIT = 1'b1
   } csr_idx_type;

   localparam logic [DUTY_W-1:0] CENTER_DUTY_RST = 8'd125;
   localparam logic [DUTY_W-1:0] SPEED_LIMIT_RST = 8'd185;

   // number of register stages between request and response
   localparam int PIPE_DEPTH = 5;
   localparam int CNT_W      = 3;

   typedef struct packed {
      logic [DUTY_W-1:0] center_duty;
      logic [DUTY_W-1:0] speed_limit;
   } cfg_type;

   typedef struct packed {
      logic                 en;
      logic [HEADING_W-1:0] addr;
   } trig_rd_type;

endpackage

[sv/mwm_trig_rom.sv]
// ----------------------------------------------------------------------------
// mwm_trig_rom
// Sine/cosine ROM indexed by raw heading; each word holds sin and cos of
// (heading mod 360 + 45 deg) quantized to the angle grid. Registered read.
// ----------------------------------------------------------------------------
module mwm_trig_rom #(
   parameter int ANGLE_STEPS        = 360,
   parameter int SINE_FRACTION_BITS = 14
) (
   input  logic                                    clock,
   input  mwm_pkg::trig_rd_type                    rd,
   output logic [2*(SINE_FRACTION_BITS+2)-1:0]     rd_data
);
   import mwm_pkg::*;

   localparam int     TRIG_W    = SINE_FRACTION_BITS + 2;
   localparam int     DEPTH     = 1 << HEADING_W;
   localparam int     DEG_TURN  = 360;
   localparam int     PHASE_DEG = 45;
   localparam longint Q30_ONE   = longint'(1) << 30;
   localparam longint HALF_Q    = longint'(1) << 29;
   localparam longint PI_Q30    = 64'sd3373259426;

   // Taylor series in Q30, v is a fraction of a quarter turn (0..pi/4)
   function automatic longint ser_sin(longint v);
      longint x;
      longint x2;
      longint t;
      x  = (v * PI_Q30) >>> 31;
      x2 = (x * x) >>> 30;
      t  = Q30_ONE - x2 / 72;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
      return (x * t) >>> 30;
   endfunction

   function automatic longint ser_cos(longint v);
      longint x;
      longint x2;
      longint t;
      x  = (v * PI_Q30) >>> 31;
      x2 = (x * x) >>> 30;
      t  = Q30_ONE - x2 / 90;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
      return t;
   endfunction

   // round half away from zero into the table format
   function automatic longint to_tab(longint q);
      longint half;
      half = longint'(1) << (29 - SINE_FRACTION_BITS);
      if (q < 0) begin
         return -((-q + half) >>> (30 - SINE_FRACTION_BITS));
      end
      return (q + half) >>> (30 - SINE_FRACTION_BITS);
   endfunction

   function automatic logic [2*TRIG_W-1:0] trig_entry(int h);
      longint     k;
      longint     step;
      longint     t;
      longint     u;
      longint     s0;
      longint     c0;
      longint     a;
      longint     b;
      logic [1:0] quad;
      k    = ((h % DEG_TURN) + PHASE_DEG) % DEG_TURN;
      step = (k * ANGLE_STEPS) / DEG_TURN;
      t    = (step << 32) / ANGLE_STEPS;
      quad = 2'((t >>> 30) & 3);
      u    = t & (Q30_ONE - 1);
      if (u < HALF_Q) begin
         s0 = ser_sin(u);
         c0 = ser_cos(u);
      end else begin
         c0 = ser_sin(Q30_ONE - u);
         s0 = ser_cos(Q30_ONE - u);
      end
      case (quad)
         2'd0: begin
            a = s0;  b = c0;
         end
         2'd1: begin
            a = c0;  b = -s0;
         end
         2'd2: begin
            a = -s0; b = -c0;
         end
         default: begin
            a = -c0; b = s0;
         end
      endcase
      return {TRIG_W'(to_tab(a)), TRIG_W'(to_tab(b))};
   endfunction

   logic [2*TRIG_W-1:0] rom_mem [DEPTH];
   logic [2*TRIG_W-1:0] rd_data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      localparam logic [2*TRIG_W-1:0] ENTRY = trig_entry(i);
      assign rom_mem[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= rom_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mwm_pipe.sv]
// ----------------------------------------------------------------------------
// mwm_pipe
// Five-stage pipeline, stalls stage by stage: speed scaling, yaw reduction,
// wheel-diagonal projection, duty saturation; rotate: same duty on all four.
// ----------------------------------------------------------------------------
module mwm_pipe #(
   parameter int SINE_FRACTION_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mwm_pkg::cfg_type                      cfg,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [mwm_pkg::HEADING_W-1:0]         req_heading_deg,
   input  logic signed [mwm_pkg::SPEED_W-1:0]    req_speed_pct,
   input  logic signed [mwm_pkg::TURN_W-1:0]     req_turn_amount,
   output mwm_pkg::trig_rd_type                  trig_rd,
   input  logic [2*(SINE_FRACTION_BITS+2)-1:0]   trig_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mwm_pkg::DUTY_W-1:0]            rsp_front_left_duty,
   output logic [mwm_pkg::DUTY_W-1:0]            rsp_front_right_duty,
   output logic [mwm_pkg::DUTY_W-1:0]            rsp_back_left_duty,
   output logic [mwm_pkg::DUTY_W-1:0]            rsp_back_right_duty
);
   import mwm_pkg::*;

   localparam int TRIG_W   = SINE_FRACTION_BITS + 2;
   localparam int PROD_W   = SPEED_W + DUTY_W + 1;   // pct * limit
   localparam int MAG_W    = 15;                     // |pct * limit| <= 32640
   localparam int RECIP_W  = 15;
   localparam int DIV_SH   = 21;                     // x/100 = x*20972 >> 21
   localparam int QUO_W    = 9;
   localparam int DIFF_W   = QUO_W + 1;
   localparam int ROT_W    = 9;
   localparam int MUL_W    = TRIG_W + DUTY_W + 1;
   localparam int SUM_W    = DUTY_W + 3;
   localparam int ROT_SIZE = 1 << SPEED_W;
   localparam logic [RECIP_W-1:0]     DIV100_RECIP = 15'd20972;
   localparam logic signed [MUL_W-1:0] TRUNC_BIAS  =
      MUL_W'((longint'(1) << SINE_FRACTION_BITS) - 1);
   localparam logic signed [SUM_W-1:0] DUTY_TOP    = SUM_W'(255);

   // rotate: -100..100 percent onto -125..130 duty offset
   function automatic logic signed [ROT_W-1:0] rot_map(int code);
      int sp;
      int m;
      sp = (code >= (ROT_SIZE / 2)) ? code - ROT_SIZE : code;
      m  = ((sp + 100) * 255) / 200 - 125;
      return ROT_W'(m);
   endfunction

   function automatic logic [DUTY_W-1:0] sat_duty(logic signed [SUM_W-1:0] v);
      if (v < 0) begin
         return '0;
      end
      if (v > DUTY_TOP) begin
         return DUTY_TOP[DUTY_W-1:0];
      end
      return v[DUTY_W-1:0];
   endfunction

   logic signed [ROT_W-1:0] rot_tbl [ROT_SIZE];

   for (genvar i = 0; i < ROT_SIZE; i++) begin : g_rot
      localparam logic signed [ROT_W-1:0] ENTRY = rot_map(i);
      assign rot_tbl[i] = ENTRY;
   end

   // ---------------- stage enables ----------------
   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign en5       = !v5_ff || rsp_ready;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign trig_rd   = {en1, req_heading_deg};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------- stage 1: pct * limit, rotate map, ROM read ----------------
   logic                     s1_action_ff;
   logic signed [ROT_W-1:0]  s1_rot_ff;
   logic signed [TURN_W-1:0] s1_turn_ff;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic signed [PROD_W-1:0] s1_prod_in;

   assign s1_prod_in = req_speed_pct * $signed({1'b0, cfg.speed_limit});

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_action_ff <= req_action;
         s1_rot_ff    <= rot_tbl[$unsigned(req_speed_pct)];
         s1_turn_ff   <= req_turn_amount;
         s1_prod_ff   <= s1_prod_in;
      end
   end

   // ---------------- stage 2: |p| * reciprocal of 100 ----------------
   logic                      s2_action_ff;
   logic signed [ROT_W-1:0]   s2_rot_ff;
   logic signed [TURN_W-1:0]  s2_turn_ff;
   logic [TURN_W-1:0]         s2_tmag_ff;
   logic [MAG_W+RECIP_W-1:0]  s2_scaled_ff;
   logic                      s2_neg_ff;
   logic [2*TRIG_W-1:0]       s2_trig_ff;
   logic [PROD_W-1:0]         s2_abs;
   logic [TURN_W-1:0]         s2_tmag_in;
   logic [MAG_W+RECIP_W-1:0]  s2_scaled_in;

   assign s2_abs       = s1_prod_ff[PROD_W-1] ? PROD_W'(-s1_prod_ff) : s1_prod_ff;
   assign s2_scaled_in = s2_abs[MAG_W-1:0] * DIV100_RECIP;
   assign s2_tmag_in   = s1_turn_ff[TURN_W-1] ? TURN_W'(-s1_turn_ff) : s1_turn_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_action_ff <= s1_action_ff;
         s2_rot_ff    <= s1_rot_ff;
         s2_turn_ff   <= s1_turn_ff;
         s2_tmag_ff   <= s2_tmag_in;
         s2_scaled_ff <= s2_scaled_in;
         s2_neg_ff    <= s1_prod_ff[PROD_W-1];
         s2_trig_ff   <= trig_data;
      end
   end

   // ---------------- stage 3: subtract yaw, clamp to 0..limit ----------------
   logic                      s3_action_ff;
   logic signed [ROT_W-1:0]   s3_rot_ff;
   logic signed [TURN_W-1:0]  s3_turn_ff;
   logic [DUTY_W-1:0]         s3_speed_ff;
   logic [2*TRIG_W-1:0]       s3_trig_ff;
   logic [QUO_W-1:0]          s3_quo;
   logic signed [DIFF_W-1:0]  s3_diff;
   logic [DUTY_W-1:0]         s3_speed_in;

   assign s3_quo  = s2_scaled_ff[DIV_SH +: QUO_W];
   assign s3_diff = $signed({1'b0, s3_quo}) - $signed({1'b0, s2_tmag_ff});

   always_comb begin
      // a negative scaled speed stays at or below zero after the yaw cut
      if (s2_neg_ff || s3_diff < 0) begin
         s3_speed_in = '0;
      end else if (s3_diff[QUO_W-1:0] > {1'b0, cfg.speed_limit}) begin
         s3_speed_in = cfg.speed_limit;
      end else begin
         s3_speed_in = s3_diff[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_action_ff <= s2_action_ff;
         s3_rot_ff    <= s2_rot_ff;
         s3_turn_ff   <= s2_turn_ff;
         s3_speed_ff  <= s3_speed_in;
         s3_trig_ff   <= s2_trig_ff;
      end
   end

   // ---------------- stage 4: speed * sin, speed * cos ----------------
   logic                      s4_action_ff;
   logic signed [ROT_W-1:0]   s4_rot_ff;
   logic signed [TURN_W-1:0]  s4_turn_ff;
   logic signed [MUL_W-1:0]   s4_pa_ff;
   logic signed [MUL_W-1:0]   s4_pb_ff;
   logic signed [MUL_W-1:0]   s4_pa_in;
   logic signed [MUL_W-1:0]   s4_pb_in;

   assign s4_pa_in = $signed({1'b0, s3_speed_ff}) * $signed(s3_trig_ff[2*TRIG_W-1:TRIG_W]);
   assign s4_pb_in = $signed({1'b0, s3_speed_ff}) * $signed(s3_trig_ff[TRIG_W-1:0]);

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_action_ff <= s3_action_ff;
         s4_rot_ff    <= s3_rot_ff;
         s4_turn_ff   <= s3_turn_ff;
         s4_pa_ff     <= s4_pa_in;
         s4_pb_ff     <= s4_pb_in;
      end
   end

   // ---------------- stage 5: truncate, mix, saturate ----------------
   logic signed [MUL_W-1:0] a_sum, b_sum, a_sh, b_sh;
   logic signed [SUM_W-1:0] a_ext, b_ext, c_ext, t_ext, r_ext;
   logic [DUTY_W-1:0]       fl_in, fr_in, bl_in, br_in;
   logic [DUTY_W-1:0]       fl_ff, fr_ff, bl_ff, br_ff;

   always_comb begin
      // truncate toward zero: bias negatives before the arithmetic shift
      a_sum = s4_pa_ff;
      b_sum = s4_pb_ff;
      if (s4_pa_ff < 0) a_sum = s4_pa_ff + TRUNC_BIAS;
      if (s4_pb_ff < 0) b_sum = s4_pb_ff + TRUNC_BIAS;
      a_sh  = a_sum >>> SINE_FRACTION_BITS;
      b_sh  = b_sum >>> SINE_FRACTION_BITS;
      a_ext = $signed(a_sh[SUM_W-1:0]);
      b_ext = $signed(b_sh[SUM_W-1:0]);
      c_ext = $signed({3'b000, cfg.center_duty});
      t_ext = s4_turn_ff;
      r_ext = s4_rot_ff;
      if (s4_action_ff) begin
         fl_in = sat_duty(c_ext + r_ext);
         fr_in = fl_in;
         bl_in = fl_in;
         br_in = fl_in;
      end else begin
         fl_in = sat_duty(c_ext + a_ext + t_ext);
         fr_in = sat_duty(c_ext - b_ext + t_ext);
         bl_in = sat_duty(c_ext + b_ext + t_ext);
         br_in = sat_duty(c_ext - a_ext + t_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         fl_ff <= fl_in;
         fr_ff <= fr_in;
         bl_ff <= bl_in;
         br_ff <= br_in;
      end
   end

   assign rsp_valid            = v5_ff;
   assign rsp_front_left_duty  = fl_ff;
   assign rsp_front_right_duty = fr_ff;
   assign rsp_back_left_duty   = bl_ff;
   assign rsp_back_right_duty  = br_ff;

endmodule

[sv/mecanum_wheel_mixer_top.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_top
// Turns drive commands into four wheel PWM duties.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one beat per command (action, heading_deg, speed_pct,
//    turn_amount). rsp_* channel: one beat per command carrying the four
//    wheel duties, in command order.
//  - Pipeline: an accepted command passes through the five pipeline
//    registers (ROM read, scaling multiply, yaw clamp, projection multiply,
//    output register) before rsp_valid rises. A new command can be taken
//    every cycle while the pipeline is not stalled; each register holds one
//    command, so up to 5 are in flight.
//  - Backpressure: a stage advances when the next one is empty or moving.
//    With rsp_ready low the output holds and bubbles ahead of it still fill,
//    so req_ready only drops once all five stages are occupied.
//  - The sin/cos table is a 512-word ROM addressed by the raw heading, so
//    heading wrap and the 45 deg phase shift cost no logic.
//  - csr_*: APB-style port. center_duty at 0x0, speed_limit at 0x4.
//    Write only while no command is in flight. pready is tied high.
//  - Reset: pipeline empties, center_duty returns to 125, speed_limit to
//    185. No clearing pass; ready the cycle after reset drops.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_top #(
   parameter int ANGLE_STEPS        = 360,
   parameter int SINE_FRACTION_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [mwm_pkg::HEADING_W-1:0]       req_heading_deg,
   input  logic signed [mwm_pkg::SPEED_W-1:0]  req_speed_pct,
   input  logic signed [mwm_pkg::TURN_W-1:0]   req_turn_amount,
   // duty channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mwm_pkg::DUTY_W-1:0]          rsp_front_left_duty,
   output logic [mwm_pkg::DUTY_W-1:0]          rsp_front_right_duty,
   output logic [mwm_pkg::DUTY_W-1:0]          rsp_back_left_duty,
   output logic [mwm_pkg::DUTY_W-1:0]          rsp_back_right_duty,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mwm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mwm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mwm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import mwm_pkg::*;

   localparam int TRIG_W = SINE_FRACTION_BITS + 2;

   // ---------------- registers ----------------
   logic [DUTY_W-1:0] center_duty_ff, center_duty_in;
   logic [DUTY_W-1:0] speed_limit_ff, speed_limit_in;
   logic              csr_wr;
   csr_idx_type       csr_idx;
   cfg_type           cfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[CSR_IDX_BIT]);

   always_comb begin
      center_duty_in = center_duty_ff;
      speed_limit_in = speed_limit_ff;
      csr_prdata     = '0;
      case (csr_idx)
         CSR_CENTER_DUTY: begin
            if (csr_wr) center_duty_in = csr_pwdata[DUTY_W-1:0];
            csr_prdata = CSR_DATA_W'(center_duty_ff);
         end
         CSR_SPEED_LIMIT: begin
            if (csr_wr) speed_limit_in = csr_pwdata[DUTY_W-1:0];
            csr_prdata = CSR_DATA_W'(speed_limit_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_duty_ff <= CENTER_DUTY_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
      end else begin
         center_duty_ff <= center_duty_in;
         speed_limit_ff <= speed_limit_in;
      end
   end

   assign cfg.center_duty = center_duty_ff;
   assign cfg.speed_limit = speed_limit_ff;

   // ---------------- datapath ----------------
   trig_rd_type         trig_rd;
   logic [2*TRIG_W-1:0] trig_data;

   mwm_trig_rom #(
      .ANGLE_STEPS        (ANGLE_STEPS),
      .SINE_FRACTION_BITS (SINE_FRACTION_BITS)
   ) u_trig_rom (
      .clock   (clock),
      .rd      (trig_rd),
      .rd_data (trig_data)
   );

   mwm_pipe #(
      .SINE_FRACTION_BITS (SINE_FRACTION_BITS)
   ) u_pipe (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_heading_deg      (req_heading_deg),
      .req_speed_pct        (req_speed_pct),
      .req_turn_amount      (req_turn_amount),
      .trig_rd              (trig_rd),
      .trig_data            (trig_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_front_left_duty  (rsp_front_left_duty),
      .rsp_front_right_duty (rsp_front_right_duty),
      .rsp_back_left_duty   (rsp_back_left_duty),
      .rsp_back_right_duty  (rsp_back_right_duty)
   );

   // ---------------- occupancy tracking ----------------
   // commands accepted but not yet delivered
   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             beat_in, beat_out;

   assign beat_in     = req_valid && req_ready;
   assign beat_out    = rsp_valid && rsp_ready;
   assign inflight_in = inflight_ff + CNT_W'(beat_in) - CNT_W'(beat_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // ---------------- assertions ----------------
   a_inflight_bound : assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more commands in flight than pipeline stages");

   a_no_phantom_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response beat with no command in flight");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == CNT_W'(PIPE_DEPTH) && !rsp_ready) |-> !req_ready)
      else $error("full pipeline still accepting while output stalled");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == '0) |-> (req_ready && !rsp_valid))
      else $error("empty pipeline not ready or showing a response");

endmodule
